// ===== design/osm_pkg.sv =====
package osm_pkg;

    localparam int VAL_W     = 31;
    localparam int K_W       = 8;
    localparam int OUT_CNT_W = 9;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef struct packed {
        logic             command;
        logic [VAL_W-1:0] value;
        logic [K_W-1:0]   rank_query;
    } in_word_t;

    typedef struct packed {
        logic [VAL_W-1:0]     kth_value;
        logic                 kth_valid;
        logic [OUT_CNT_W-1:0] insert_rank;
        logic                 add_dropped;
        logic                 remove_hit;
        logic [OUT_CNT_W-1:0] set_size;
    } out_word_t;

    // per-cycle orders broadcast to every cell of the chain
    typedef struct packed {
        logic compare;
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

// ===== design/osm_stream.sv =====
interface osm_stream #(parameter type data_t = logic) ();

    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== design/osm_cell.sv =====
module osm_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 9
) (
    input  logic                        clk,
    input  osm_pkg::cell_ctrl_t         ctrl,
    input  logic [osm_pkg::VAL_W-1:0]   key,
    input  logic [CNT_W-1:0]            count,
    input  logic [osm_pkg::K_W-1:0]     rank_k,
    input  logic                        left_lt,
    input  logic [osm_pkg::VAL_W-1:0]   left_val,
    input  logic [osm_pkg::VAL_W-1:0]   right_val,
    output logic [osm_pkg::VAL_W-1:0]   val,
    output logic                        lt,
    output logic                        eq,
    output logic                        boundary,
    output logic                        kth_hit
);
    import osm_pkg::*;

    logic [VAL_W-1:0] val_reg;
    logic             lt_reg;
    logic             eq_reg;
    logic             occupied;

    assign occupied = 32'(count) > 32'(IDX);

    // first cell not below the key; insert lands here, remove starts here
    assign boundary = !lt_reg && left_lt;
    assign kth_hit  = occupied && (32'(rank_k) == 32'(IDX));

    always_ff @(posedge clk)
    begin
        if (ctrl.compare)
        begin
            lt_reg <= occupied && (val_reg < key);
            eq_reg <= occupied && (val_reg == key);
        end
        if (ctrl.insert)
        begin
            if (!lt_reg)
            begin
                val_reg <= left_lt ? key : left_val;
            end
        end
        else if (ctrl.remove)
        begin
            if (!lt_reg)
            begin
                val_reg <= right_val;
            end
        end
    end

    assign val = val_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

// ===== design/osm_select.sv =====
module osm_select #(
    parameter int N = 256,
    parameter int W = 8
) (
    input  logic         clk,
    input  logic [N-1:0] sel,
    input  logic [W-1:0] data [N],
    output logic         found,
    output logic [W-1:0] result
);
    localparam int G  = 16;
    localparam int NG = (N + G - 1) / G;

    logic [W-1:0]  grp_reg [NG];
    logic [NG-1:0] grp_any_reg;
    logic [W-1:0]  result_reg;
    logic          found_reg;
    logic [W-1:0]  result_next;
    logic          found_next;

    // first level: or of the selected entries within each group of cells
    for (genvar g = 0; g < NG; g++)
    begin : g_grp
        localparam int LO = g * G;
        localparam int HI = ((g + 1) * G < N) ? (g + 1) * G : N;

        logic [W-1:0] grp_next;
        logic         grp_any_next;

        always_comb
        begin
            grp_next     = '0;
            grp_any_next = 1'b0;
            for (int j = LO; j < HI; j++)
            begin
                if (sel[j])
                begin
                    grp_next     = grp_next | data[j];
                    grp_any_next = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            grp_reg[g]     <= grp_next;
            grp_any_reg[g] <= grp_any_next;
        end
    end

    always_comb
    begin
        result_next = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (grp_any_reg[g])
            begin
                result_next = result_next | grp_reg[g];
            end
        end
        found_next = |grp_any_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        found_reg  <= found_next;
    end

    assign result = result_reg;
    assign found  = found_reg;

endmodule

// ===== design/order_statistic_multiset_unit.sv =====
// one word at a time: no new input word is accepted until the result word is loaded,
// and the load waits while the previous result word has not been taken
// a result word comes from the pass through the cell chain: compare, two-level
// boundary select, shift, two-level k-th select, then the output register
// reset: rst_n (async, active low) empties the set and the control state;
// cell contents stay undefined and need no clearing pass
module order_statistic_multiset_unit #(
    parameter int CAPACITY = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    osm_stream.sink   item_chan,
    osm_stream.source result_chan
);
    import osm_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_RED1,
        S_RED2,
        S_UPD,
        S_K1,
        S_K2,
        S_LOAD
    } state_t;

    state_t            state_reg;
    logic              cmd_reg;
    logic [VAL_W-1:0]  key_reg;
    logic [K_W-1:0]    k_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  rank_reg;
    logic              hit_reg;
    logic              drop_reg;
    out_word_t         out_reg;
    logic              out_valid_reg;

    cell_ctrl_t        ctrl;
    logic              full;
    logic              kth_valid;

    // cell chain wiring
    logic [VAL_W-1:0]  cell_val [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_bnd;
    logic [CAPACITY-1:0] cell_kth;

    // boundary select carries the equal flag above the cell index
    logic [IDX_W:0]    bnd_data [CAPACITY];
    logic              bnd_found;
    logic [IDX_W:0]    bnd_result;
    logic              kth_found;
    logic [VAL_W-1:0]  kth_result;

    assign full = (32'(count_reg) == 32'(CAPACITY));

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic             left_lt;
        logic [VAL_W-1:0] left_val;
        logic [VAL_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            // left edge acts as a value below everything
            assign left_lt  = 1'b1;
            assign left_val = cell_val[i];
        end
        else
        begin : g_mid
            assign left_lt  = cell_lt[i-1];
            assign left_val = cell_val[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_val = cell_val[i];
        end
        else
        begin : g_inner
            assign right_val = cell_val[i+1];
        end

        osm_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .key       (key_reg),
            .count     (count_reg),
            .rank_k    (k_reg),
            .left_lt   (left_lt),
            .left_val  (left_val),
            .right_val (right_val),
            .val       (cell_val[i]),
            .lt        (cell_lt[i]),
            .eq        (cell_eq[i]),
            .boundary  (cell_bnd[i]),
            .kth_hit   (cell_kth[i])
        );

        assign bnd_data[i] = {cell_eq[i], IDX_W'(i)};
    end

    // finds the insert point and whether a copy of the key sits there
    osm_select #(
        .N (CAPACITY),
        .W (IDX_W + 1)
    ) u_bnd_sel (
        .clk    (clk),
        .sel    (cell_bnd),
        .data   (bnd_data),
        .found  (bnd_found),
        .result (bnd_result)
    );

    // reads the k-th smallest value after the update
    osm_select #(
        .N (CAPACITY),
        .W (VAL_W)
    ) u_kth_sel (
        .clk    (clk),
        .sel    (cell_kth),
        .data   (cell_val),
        .found  (kth_found),
        .result (kth_result)
    );

    // orders to the cells: compare against the key, then shift once
    always_comb
    begin
        ctrl.compare = (state_reg == S_CMP);
        ctrl.insert  = (state_reg == S_UPD) && (cmd_reg == CMD_ADD) && !full;
        ctrl.remove  = (state_reg == S_UPD) && (cmd_reg == CMD_REMOVE)
                       && bnd_found && bnd_result[IDX_W];
    end

    assign kth_valid = (32'(k_reg) < 32'(count_reg)) && kth_found;

    assign item_chan.ready   = (state_reg == S_IDLE);
    assign result_chan.valid = out_valid_reg;
    assign result_chan.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a load in the same cycle keeps the flag set
            if (out_valid_reg && result_chan.ready && (state_reg != S_LOAD))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_chan.valid)
                    begin
                        cmd_reg   <= item_chan.data.command;
                        key_reg   <= item_chan.data.value;
                        k_reg     <= item_chan.data.rank_query;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_RED1;
                end
                S_RED1:
                begin
                    state_reg <= S_RED2;
                end
                S_RED2:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    // no boundary means every stored value is below the key
                    if (cmd_reg == CMD_ADD)
                    begin
                        rank_reg <= bnd_found ? CNT_W'(bnd_result[IDX_W-1:0])
                                              : count_reg;
                    end
                    else
                    begin
                        rank_reg <= '0;
                    end
                    drop_reg <= (cmd_reg == CMD_ADD) && full;
                    hit_reg  <= ctrl.remove;
                    if (ctrl.insert)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    else if (ctrl.remove)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                    state_reg <= S_K1;
                end
                S_K1:
                begin
                    state_reg <= S_K2;
                end
                S_K2:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    // wait until the previous result word has been taken
                    if (!out_valid_reg || result_chan.ready)
                    begin
                        out_reg.kth_value   <= kth_valid ? kth_result : '0;
                        out_reg.kth_valid   <= kth_valid;
                        out_reg.insert_rank <= OUT_CNT_W'(rank_reg);
                        out_reg.add_dropped <= drop_reg;
                        out_reg.remove_hit  <= hit_reg;
                        out_reg.set_size    <= OUT_CNT_W'(count_reg);
                        out_valid_reg       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // an accepted add grows the set by exactly one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert |=> count_reg == CNT_W'($past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the set by one");

    // an add to a full set is flagged and leaves the size alone
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && cmd_reg == CMD_ADD && full)
        |=> drop_reg && $stable(count_reg))
        else $error("add to full set not dropped");

    // a remove only shifts a non-empty set on a remove command
    a_remove_legal: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.remove |-> (cmd_reg == CMD_REMOVE) && (count_reg != '0))
        else $error("remove shift on empty set or wrong command");

    // a result word appears only out of the load step
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_LOAD))
        else $error("result word raised outside load step");

endmodule
